### hw/rtl/flp_pkg.sv
// ----------------------------------------------------------------------------
// flp_pkg: shared constants and table builders for the four-pole ladder
// Default widths, fixed field widths and the elaboration-time functions that
// fill the sine and arctangent lookup tables.
// ----------------------------------------------------------------------------
package flp_pkg;

   localparam int SAMPLE_BITS_DEF      = 24;
   localparam int FRAC_BITS_DEF        = 16;
   localparam int SINE_TABLE_DEPTH_DEF = 1024;
   localparam int ATAN_TABLE_DEPTH_DEF = 1024;

   localparam int CUT_BITS    = 16;
   localparam int RES_BITS    = 16;
   localparam int PERIOD_BITS = 32;
   localparam int OUT_BITS    = 21;
   localparam int ATAN_BITS   = 30;

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 32'd89478;
   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Restoring division, elaboration use only.
   function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bit_v;
      n = n_in;
      res = '0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bit_v > n) bit_v = bit_v >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bit_v != 0) begin
            if (n >= res + bit_v) begin
               n = n - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] sine_q30(input logic [63:0] th);
      logic [63:0] t2;
      logic [63:0] x;
      t2 = (th * th) >> 30;
      x = Q30_ONE - t2 / 72;
      x = Q30_ONE - ((t2 * x) >> 30) / 42;
      x = Q30_ONE - ((t2 * x) >> 30) / 20;
      x = Q30_ONE - ((t2 * x) >> 30) / 6;
      return (th * x) >> 30;
   endfunction

   // Full-turn sine entry k of a depth-d table, rounded to Q.frac.
   function automatic logic [63:0] sine_entry(input logic [63:0] k, input logic [63:0] d,
                                              input int frac);
      logic [63:0] m;
      logic [63:0] num;
      logic [63:0] sv;
      logic [63:0] mag;
      logic        neg;
      m = 4 * k;
      neg = 1'b0;
      if (m <= d) begin
         num = m;
      end else if (m <= 2 * d) begin
         num = 2 * d - m;
      end else if (m <= 3 * d) begin
         num = m - 2 * d;
         neg = 1'b1;
      end else begin
         num = 4 * d - m;
         neg = 1'b1;
      end
      sv = sine_q30(div_u64(num * HALF_PI_Q30, d));
      mag = (sv + (64'd1 << (29 - frac))) >> (30 - frac);
      return neg ? (64'd0 - mag) : mag;
   endfunction

   // atan(k/d) in Q30 through one half-angle step and an eight-term series.
   function automatic logic [63:0] atan_entry(input logic [63:0] k, input logic [63:0] d);
      logic [63:0] t;
      logic [63:0] v;
      logic [63:0] s;
      logic [63:0] h;
      logic [63:0] h2;
      logic [63:0] term;
      logic [63:0] q;
      logic [63:0] sum;
      t = div_u64(k << 30, d);
      v = Q30_ONE + ((t * t) >> 30);
      s = isqrt64(v << 30);
      h = div_u64(t << 30, Q30_ONE + s);
      h2 = (h * h) >> 30;
      term = h;
      sum = '0;
      for (int n = 0; n < 8; n++) begin
         q = div_u64(term, 64'(2 * n + 1));
         sum = n[0] ? (sum - q) : (sum + q);
         term = (term * h2) >> 30;
      end
      return sum << 1;
   endfunction

endpackage

### hw/rtl/four_pole_saturating_ladder_lowpass.sv
// ----------------------------------------------------------------------------
// four_pole_saturating_ladder_lowpass: saturating four-pole ladder low-pass
// A small sequencer drives one shared multiplier and one shared divider
// through the coefficient, feedback and four stage updates of each sample.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one transaction per audio sample: the sample, a cutoff in
//   hertz and a resonance. rsp_* returns the new fourth-stage output.
//   csr_wr_en/csr_wr_data set the sample period (Q0.32 seconds); write it
//   only while no sample is in flight.
// Sequencing:
//   The bit-serial divider runs once for the feedback gain and again for
//   each soft clip of a value above ten (five clips); a clip at or below
//   ten skips the divider.
//   req_tready is high only while the sequencer is idle, the cycle after the
//   result is loaded, so a new sample is accepted only after the last is done.
// Reset:
//   Synchronous reset clears the four stages, restores the 48 kHz period
//   and drops any pending result.
// Stall:
//   A finished result waits in the output register; if an earlier result
//   is still held, the sequencer waits before writing the new one.
// ----------------------------------------------------------------------------
module four_pole_saturating_ladder_lowpass
   import flp_pkg::*;
#(
   parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
   parameter int FRAC_BITS        = FRAC_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
   parameter int ATAN_TABLE_DEPTH = ATAN_TABLE_DEPTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // sample_in, cutoff_hz, resonance_amount
   input  logic [((SAMPLE_BITS+39)/8)*8-1:0]        req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // sample_out
   output logic [((OUT_BITS+7)/8)*8-1:0]            rsp_tdata,
   input  logic                                     csr_wr_en,
   input  logic [PERIOD_BITS-1:0]                   csr_wr_data
);

   localparam int SB    = SAMPLE_BITS;
   localparam int F     = FRAC_BITS;
   localparam int SD    = SINE_TABLE_DEPTH;
   localparam int AD    = ATAN_TABLE_DEPTH;
   localparam int RSP_W = ((OUT_BITS + 7) / 8) * 8;
   localparam int SK_W  = $clog2(SD);
   localparam int AA_W  = $clog2(AD + 1);
   localparam int SIN_W = F + 2;
   localparam int R_W   = F + 2;
   localparam int Y_W   = F + 4;
   localparam int YS_W  = F + 5;
   localparam int DRV_W = SB + 6;
   localparam int MAG_W = (F + 9 > SB + 7) ? F + 9 : SB + 7;
   localparam int V_W   = MAG_W + 1;
   localparam int DW_A  = (2 * F + 3 > F + 18) ? 2 * F + 3 : F + 18;
   localparam int DIV_W = (DW_A > SB + 9) ? DW_A : SB + 9;
   localparam int MA_A  = (F + 5 > 17) ? F + 5 : 17;
   localparam int MA_B  = ($clog2(2 * AD + 1) + 1 > $clog2(SD + 1) + 1) ?
                          $clog2(2 * AD + 1) + 1 : $clog2(SD + 1) + 1;
   localparam int MA_W  = (MA_A > MA_B) ? MA_A : MA_B;
   localparam int MB_A  = (MAG_W + 1 > 34) ? MAG_W + 1 : 34;
   localparam int MB_W  = (MB_A > SB + 7) ? MB_A : SB + 7;
   localparam int P_W   = MA_W + MB_W;
   localparam int CW    = ((YS_W > SB) ? YS_W : SB) + 1;
   localparam int OX_W  = (SB > OUT_BITS) ? SB : OUT_BITS;
   localparam int YSH   = 30 - F;
   localparam int TEN_W = 35;

   localparam logic [F-1:0] F_LOW  = F'(((64'd1 << F) + 64'd50) / 64'd100);
   localparam logic [F-1:0] F_HIGH = F'((64'd1 << F) - 64'(F_LOW));
   localparam logic [MAG_W-1:0] LIM_M   = MAG_W'(64'd10 << F);
   localparam logic [DIV_W-1:0] LIM_D   = DIV_W'(64'd10 << F);
   localparam logic [DIV_W-1:0] LIMAD_D = DIV_W'((64'd20 * 64'(AD)) << F);
   localparam logic [DIV_W-1:0] ONE_D   = DIV_W'(64'd1 << F);
   localparam logic [15:0] FIFTH_RECIP  = 16'd52429;
   localparam logic [ATAN_BITS:0] HALF_PI_A = (ATAN_BITS + 1)'(HALF_PI_Q30);
   localparam logic [TEN_W-1:0] HALF_Y = TEN_W'(64'd1 << (YSH - 1));
   localparam logic signed [CW-1:0] SAT_HI = {{(CW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
   localparam logic signed [CW-1:0] SAT_LO = ~SAT_HI;

   typedef enum logic [16:0] {
      ST_IDLE       = 17'h00001,
      ST_PHASE      = 17'h00002,
      ST_INDEX      = 17'h00004,
      ST_SADDR      = 17'h00008,
      ST_SREAD      = 17'h00010,
      ST_COEF       = 17'h00020,
      ST_FBDIV      = 17'h00040,
      ST_CLIP_MUL   = 17'h00080,
      ST_CLIP_START = 17'h00100,
      ST_CLIP_WAIT  = 17'h00200,
      ST_CLIP_ROM   = 17'h00400,
      ST_CLIP_END   = 17'h00800,
      ST_FBTERM     = 17'h01000,
      ST_DRIVE      = 17'h02000,
      ST_ADV        = 17'h04000,
      ST_SUM        = 17'h08000,
      ST_OUT        = 17'h10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   logic [PERIOD_BITS-1:0]  period_ff;
   logic signed [SB-1:0]    stage_ff [4];
   logic [1:0]              j_ff;
   logic                    fb_phase_ff;
   logic                    rsp_valid_ff;
   logic [OUT_BITS-1:0]     out_ff;

   logic signed [SB-1:0]    x_ff;
   logic [CUT_BITS-1:0]     cut_ff;
   logic [RES_BITS-1:0]     res_ff;
   logic signed [P_W-1:0]   prod_ff;
   logic [SK_W-1:0]         sine_addr_ff;
   logic [AA_W-1:0]         atan_addr_ff;
   logic [F-1:0]            f_ff;
   logic [R_W-1:0]          r_ff;
   logic [Y_W-1:0]          fb_ff;
   logic signed [DRV_W-1:0] drive_ff;
   logic [MAG_W-1:0]        clip_mag_ff;
   logic                    clip_neg_ff;
   logic                    below_lim_ff;

   logic signed [MA_W-1:0]  mul_a;
   logic signed [MB_W-1:0]  mul_b;
   logic signed [P_W-1:0]   rnd_prod;
   logic signed [SIN_W-1:0] sine_q;
   logic [ATAN_BITS-1:0]    atan_q;
   logic                    div_start;
   logic [DIV_W-1:0]        div_dividend;
   logic [DIV_W-1:0]        div_divisor;
   logic                    div_done;
   logic [DIV_W-1:0]        div_quot;

   logic                    out_free;
   logic [P_W-34:0]         k_full;
   logic [SK_W-1:0]         k_addr;
   logic signed [F+2:0]     f2;
   logic [F-1:0]            f_next;
   logic [16+F-1:0]         r_wide;
   logic [R_W-1:0]          r_next;
   logic                    below_lim;
   logic [DIV_W-1:0]        near_sum;
   logic [17:0]             near_n;
   logic [33:0]             near_prod;
   logic [15:0]             near_q;
   logic [AA_W-1:0]         near_idx;
   logic [AA_W-1:0]         a_idx;
   logic [ATAN_BITS:0]      ang;
   logic [TEN_W-1:0]        ten_ang;
   logic [TEN_W-1:0]        y_full;
   logic [Y_W-1:0]          y_mag;
   logic signed [YS_W-1:0]  y_s;
   logic signed [CW-1:0]    y_x;
   logic signed [CW-1:0]    sat_x;
   logic signed [SB-1:0]    sat_val;
   logic signed [SB-1:0]    stage_j;
   logic signed [V_W-1:0]   v_sum;
   logic [V_W-1:0]          v_abs;
   logic signed [OX_W-1:0]  out_ext;

   function automatic logic signed [P_W-1:0] round_shift(input logic signed [P_W-1:0] p);
      logic [P_W-1:0] m;
      m = p[P_W-1] ? P_W'(-p) : P_W'(p);
      m = (m + (P_W'(1) << (F - 1))) >> F;
      return p[P_W-1] ? -$signed(m) : $signed(m);
   endfunction

   flp_div #(
      .W(DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   flp_rom #(
      .FRAC_BITS        (F),
      .SINE_TABLE_DEPTH (SD),
      .ATAN_TABLE_DEPTH (AD)
   ) u_rom (
      .clock     (clock),
      .sine_addr (sine_addr_ff),
      .sine_data (sine_q),
      .atan_addr (atan_addr_ff),
      .atan_data (atan_q)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - OUT_BITS){1'b0}}, out_ff};
   assign rnd_prod   = round_shift(prod_ff);
   assign stage_j    = stage_ff[j_ff];

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_PHASE: begin
            mul_a = MA_W'(cut_ff);
            mul_b = MB_W'(period_ff);
         end
         ST_INDEX: begin
            mul_a = MA_W'(SD);
            mul_b = MB_W'(prod_ff[32:0]);
         end
         ST_CLIP_MUL: begin
            mul_a = MA_W'(2 * AD);
            mul_b = MB_W'(clip_mag_ff);
         end
         ST_FBTERM: begin
            mul_a = MA_W'(fb_ff);
            mul_b = MB_W'(stage_ff[0]) - MB_W'(stage_ff[1]);
         end
         ST_ADV: begin
            mul_a = MA_W'(f_ff);
            mul_b = MB_W'(drive_ff) - MB_W'(stage_j);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // coefficient, table index and soft-clip arithmetic
   always_comb begin
      k_full = prod_ff[P_W-1:33];
      k_addr = (k_full > (P_W - 33)'(SD - 1)) ? SK_W'(SD - 1) : k_full[SK_W-1:0];

      f2 = {sine_q, 1'b0};
      if (f2 > $signed({3'b000, F_HIGH})) begin
         f_next = F_HIGH;
      end else if (f2 < $signed({3'b000, F_LOW})) begin
         f_next = F_LOW;
      end else begin
         f_next = f2[F-1:0];
      end

      r_wide = {res_ff, {F{1'b0}}} >> 14;
      r_next = r_wide[R_W-1:0];

      below_lim = clip_mag_ff <= LIM_M;

      // divide by 20<<F: shift out 4<<F, then multiply by the reciprocal of five
      near_sum  = prod_ff[DIV_W-1:0] + LIM_D;
      near_n    = 18'(near_sum >> (F + 2));
      near_prod = 34'(near_n) * 34'(FIFTH_RECIP);
      near_q    = near_prod[33:18];
      near_idx  = (near_q > 16'(AD)) ? AA_W'(AD) : near_q[AA_W-1:0];

      a_idx = (div_quot > DIV_W'(AD)) ? AA_W'(AD) : div_quot[AA_W-1:0];

      ang     = below_lim_ff ? {1'b0, atan_q} : HALF_PI_A - {1'b0, atan_q};
      ten_ang = (TEN_W'(ang) << 3) + (TEN_W'(ang) << 1);
      y_full  = (ten_ang + HALF_Y) >> YSH;
      y_mag   = y_full[Y_W-1:0];
      y_s     = clip_neg_ff ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
      y_x     = CW'(y_s);
      if (y_x > SAT_HI) begin
         sat_x = SAT_HI;
      end else if (y_x < SAT_LO) begin
         sat_x = SAT_LO;
      end else begin
         sat_x = y_x;
      end
      sat_val = sat_x[SB-1:0];

      v_sum = V_W'(stage_j) + rnd_prod[V_W-1:0];
      v_abs = v_sum[V_W-1] ? V_W'(-v_sum) : V_W'(v_sum);

      out_ext = OX_W'(stage_ff[3]);
   end

   // shared divider operand select
   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         ST_COEF: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(r_next) << F;
            div_divisor  = ONE_D - DIV_W'(f_next);
         end
         ST_CLIP_START: begin
            if (!below_lim) begin
               div_start    = 1'b1;
               div_dividend = LIMAD_D + DIV_W'(clip_mag_ff);
               div_divisor  = DIV_W'({clip_mag_ff, 1'b0});
            end
         end
         default: begin
            div_start    = 1'b0;
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_tvalid) state_in = ST_PHASE;
         ST_PHASE:      state_in = ST_INDEX;
         ST_INDEX:      state_in = ST_SADDR;
         ST_SADDR:      state_in = ST_SREAD;
         ST_SREAD:      state_in = ST_COEF;
         ST_COEF:       state_in = ST_FBDIV;
         ST_FBDIV:      if (div_done) state_in = ST_CLIP_MUL;
         ST_CLIP_MUL:   state_in = ST_CLIP_START;
         ST_CLIP_START: state_in = below_lim ? ST_CLIP_ROM : ST_CLIP_WAIT;
         ST_CLIP_WAIT:  if (div_done) state_in = ST_CLIP_ROM;
         ST_CLIP_ROM:   state_in = ST_CLIP_END;
         ST_CLIP_END: begin
            if (fb_phase_ff) begin
               state_in = ST_FBTERM;
            end else if (j_ff == 2'd3) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_FBTERM:     state_in = ST_DRIVE;
         ST_DRIVE:      state_in = ST_ADV;
         ST_ADV:        state_in = ST_SUM;
         ST_SUM:        state_in = ST_CLIP_MUL;
         ST_OUT:        if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
         j_ff         <= '0;
         fb_phase_ff  <= 1'b0;
         for (int i = 0; i < 4; i++) stage_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) period_ff <= csr_wr_data;
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_FBDIV: if (div_done) fb_phase_ff <= 1'b1;
            ST_DRIVE: begin
               fb_phase_ff <= 1'b0;
               j_ff        <= '0;
            end
            ST_CLIP_END: begin
               if (!fb_phase_ff) begin
                  stage_ff[j_ff] <= sat_val;
                  if (j_ff != 2'd3) j_ff <= j_ff + 2'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_ff   <= req_tdata[SB-1:0];
               cut_ff <= req_tdata[SB+CUT_BITS-1:SB];
               res_ff <= req_tdata[SB+CUT_BITS+RES_BITS-1:SB+CUT_BITS];
            end
         end
         ST_SADDR: sine_addr_ff <= k_addr;
         ST_COEF: begin
            f_ff <= f_next;
            r_ff <= r_next;
         end
         ST_FBDIV: begin
            if (div_done) begin
               clip_mag_ff <= MAG_W'(r_ff) + div_quot[MAG_W-1:0];
               clip_neg_ff <= 1'b0;
            end
         end
         ST_CLIP_START: begin
            below_lim_ff <= below_lim;
            if (below_lim) atan_addr_ff <= near_idx;
         end
         ST_CLIP_WAIT: if (div_done) atan_addr_ff <= a_idx;
         ST_CLIP_END: begin
            if (fb_phase_ff) begin
               fb_ff <= y_mag;
            end else begin
               drive_ff <= DRV_W'(sat_val);
            end
         end
         ST_DRIVE: drive_ff <= DRV_W'(x_ff) + rnd_prod[DRV_W-1:0];
         ST_SUM: begin
            clip_mag_ff <= v_abs[MAG_W-1:0];
            clip_neg_ff <= v_sum[V_W-1];
         end
         ST_OUT: if (out_free) out_ff <= out_ext[OUT_BITS-1:0];
         default: begin
         end
      endcase
   end

endmodule

### hw/rtl/flp_div.sv
// ----------------------------------------------------------------------------
// flp_div: shared unsigned divider
// Restoring division, one quotient bit per cycle; done pulses once the
// quotient is complete.
// ----------------------------------------------------------------------------
module flp_div #(
   parameter int W = 35
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int CNT_W = $clog2(W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [W-1:0]     rem_ff;
   logic [W-1:0]     quo_ff;
   logic [W-1:0]     den_ff;

   logic [W:0]   shifted;
   logic [W:0]   trial;
   logic         fits;
   logic [W-1:0] rem_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = fits ? trial[W-1:0] : shifted[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hw/rtl/flp_rom.sv
// ----------------------------------------------------------------------------
// flp_rom: sine and arctangent lookup tables
// Constant tables built at elaboration, each read through a registered port.
// ----------------------------------------------------------------------------
module flp_rom
   import flp_pkg::*;
#(
   parameter int FRAC_BITS        = FRAC_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
   parameter int ATAN_TABLE_DEPTH = ATAN_TABLE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]   sine_addr,
   output logic signed [FRAC_BITS+1:0]           sine_data,
   input  logic [$clog2(ATAN_TABLE_DEPTH+1)-1:0] atan_addr,
   output logic [ATAN_BITS-1:0]                  atan_data
);

   localparam int SIN_W = FRAC_BITS + 2;

   logic signed [SIN_W-1:0]   sine_rom [SINE_TABLE_DEPTH];
   logic [ATAN_BITS-1:0]      atan_rom [ATAN_TABLE_DEPTH+1];

   for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
      localparam logic [63:0] SV = sine_entry(64'(g), 64'(SINE_TABLE_DEPTH), FRAC_BITS);
      assign sine_rom[g] = SV[SIN_W-1:0];
   end

   for (genvar g = 0; g <= ATAN_TABLE_DEPTH; g++) begin : g_atan
      localparam logic [63:0] AV = atan_entry(64'(g), 64'(ATAN_TABLE_DEPTH));
      assign atan_rom[g] = AV[ATAN_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      sine_data <= sine_rom[sine_addr];
      atan_data <= atan_rom[atan_addr];
   end

endmodule
